// ----- rtl/mbp_pkg.sv -----
// Shared constants and types for the MSB-first bit packer.
package mbp_pkg;

   localparam int MAX_FIELD_BITS = 32;
   localparam int FIELD_W        = 32;
   localparam int NUM_BITS_W     = 6;
   localparam int BYTE_W         = 8;
   localparam int PEND_W         = 3;

   // Pending bits plus one full field, with room for the partial byte on top.
   localparam int ACC_W     = BYTE_W + MAX_FIELD_BITS;
   localparam int MAX_BYTES = (BYTE_W - 1 + MAX_FIELD_BITS) / BYTE_W;
   localparam int OUT_BITS  = MAX_BYTES * BYTE_W;
   localparam int NB_W      = $clog2(MAX_FIELD_BITS + 1);
   localparam int TOT_W     = $clog2(ACC_W);
   localparam int SH_W      = $clog2(ACC_W + 1);
   localparam int CNT_W     = $clog2(MAX_BYTES + 1);

   localparam int Q_DEPTH = 2;
   localparam int QPTR_W  = $clog2(Q_DEPTH);
   localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_FLUSH = 1'b1;

   typedef struct packed {
      logic [OUT_BITS-1:0] data;
      logic [CNT_W-1:0]    count;
   } mbp_entry_type;

endpackage

// ----- rtl/mbp_front.sv -----
// Front end: accepts transactions, merges bits into the partial byte, forms byte groups.
module mbp_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic                          mode,
   input  logic [mbp_pkg::FIELD_W-1:0]   field_value,
   input  logic [mbp_pkg::NUM_BITS_W-1:0] num_bits,
   output logic                          q_push,
   output mbp_pkg::mbp_entry_type        q_entry
);

   logic [mbp_pkg::BYTE_W-1:0] partial_ff, partial_in;
   logic [mbp_pkg::PEND_W-1:0] pending_ff, pending_in;

   logic [mbp_pkg::NB_W-1:0]                    nb;
   logic [mbp_pkg::ACC_W+mbp_pkg::FIELD_W-1:0]  fv_wide;
   logic [mbp_pkg::ACC_W-1:0]                   val_m;
   logic [mbp_pkg::ACC_W-1:0]                   acc;
   logic [mbp_pkg::ACC_W-1:0]                   rest;
   logic [mbp_pkg::SH_W-1:0]                    sh;
   logic [mbp_pkg::TOT_W-1:0]                   total;
   logic [mbp_pkg::CNT_W-1:0]                   bytes;

   always_comb begin
      if (num_bits > mbp_pkg::NUM_BITS_W'(mbp_pkg::MAX_FIELD_BITS)) begin
         nb = mbp_pkg::NB_W'(mbp_pkg::MAX_FIELD_BITS);
      end else begin
         nb = num_bits[mbp_pkg::NB_W-1:0];
      end
      fv_wide = {{mbp_pkg::ACC_W{1'b0}}, field_value};
      // keep only the low nb bits; bits beyond the field port read as zero
      for (int i = 0; i < mbp_pkg::ACC_W; i++) begin
         val_m[i] = (i < int'(nb)) ? fv_wide[i] : 1'b0;
      end
      sh    = mbp_pkg::SH_W'(mbp_pkg::ACC_W) - mbp_pkg::SH_W'(pending_ff)
              - mbp_pkg::SH_W'(nb);
      acc   = {partial_ff, {(mbp_pkg::ACC_W - mbp_pkg::BYTE_W){1'b0}}} | (val_m << sh);
      total = mbp_pkg::TOT_W'(pending_ff) + mbp_pkg::TOT_W'(nb);
      bytes = mbp_pkg::CNT_W'(total >> 3);
      rest  = acc << {total[mbp_pkg::TOT_W-1:3], 3'b000};

      partial_in = partial_ff;
      pending_in = pending_ff;
      q_push     = 1'b0;
      q_entry.data  = acc[mbp_pkg::ACC_W-1 -: mbp_pkg::OUT_BITS];
      q_entry.count = bytes;

      if (accept) begin
         if (mode == mbp_pkg::MODE_FLUSH) begin
            q_entry.data  = {partial_ff, {(mbp_pkg::OUT_BITS - mbp_pkg::BYTE_W){1'b0}}};
            q_entry.count = mbp_pkg::CNT_W'(1);
            if (pending_ff != '0) begin
               q_push     = 1'b1;
               partial_in = '0;
               pending_in = '0;
            end
         end else begin
            q_push     = (bytes != '0);
            partial_in = rest[mbp_pkg::ACC_W-1 -: mbp_pkg::BYTE_W];
            pending_in = total[mbp_pkg::PEND_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         pending_ff <= '0;
      end else begin
         partial_ff <= partial_in;
         pending_ff <= pending_in;
      end
   end

endmodule

// ----- rtl/mbp_queue.sv -----
// Short queue of byte groups between the front and back ends.
module mbp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  mbp_pkg::mbp_entry_type push_entry,
   input  logic                   pop,
   output mbp_pkg::mbp_entry_type head_entry,
   output logic                   q_full,
   output logic                   q_valid
);

   mbp_pkg::mbp_entry_type entry_ff [mbp_pkg::Q_DEPTH];
   logic [mbp_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [mbp_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [mbp_pkg::QCNT_W-1:0] cnt_ff, cnt_in;
   logic do_push, do_pop;

   assign q_full     = (cnt_ff == mbp_pkg::QCNT_W'(mbp_pkg::Q_DEPTH));
   assign q_valid    = (cnt_ff != '0);
   assign head_entry = entry_ff[rd_ptr_ff];
   assign do_push    = push && !q_full;
   assign do_pop     = pop && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == mbp_pkg::QPTR_W'(mbp_pkg::Q_DEPTH - 1)) ? '0
                     : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == mbp_pkg::QPTR_W'(mbp_pkg::Q_DEPTH - 1)) ? '0
                     : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- rtl/mbp_back.sv -----
// Back end: sends each byte group out one byte per transaction, marking the last.
module mbp_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   input  mbp_pkg::mbp_entry_type      head_entry,
   output logic                        q_pop,
   input  logic                        pop,
   output logic                        empty,
   output logic [mbp_pkg::BYTE_W-1:0]  out_byte,
   output logic                        last_byte
);

   logic                         busy_ff, busy_in;
   logic [mbp_pkg::CNT_W-1:0]    rem_ff, rem_in;
   logic [mbp_pkg::OUT_BITS-1:0] data_ff, data_in;
   logic                         sent;

   assign empty     = !busy_ff;
   assign out_byte  = data_ff[mbp_pkg::OUT_BITS-1 -: mbp_pkg::BYTE_W];
   assign last_byte = (rem_ff == mbp_pkg::CNT_W'(1));
   assign sent      = busy_ff && pop;

   always_comb begin
      busy_in = busy_ff;
      rem_in  = rem_ff;
      data_in = data_ff;
      q_pop   = 1'b0;
      if (!busy_ff || (sent && last_byte)) begin
         // load the next group as soon as the current one is done
         q_pop   = q_valid;
         busy_in = q_valid;
         rem_in  = head_entry.count;
         data_in = head_entry.data;
      end else if (sent) begin
         rem_in  = rem_ff - 1'b1;
         data_in = data_ff << mbp_pkg::BYTE_W;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      data_ff <= data_in;
   end

endmodule

// ----- rtl/msb_first_bit_packer.sv -----
// MSB-first bit packer top level.
// Bytes pass the queue entry, then the back-end data register, to the result ports.
// Throughput: one byte per cycle on the result side while pop is held; a write filling N
// bytes (at most 4) is sent by the back end one byte per pop.
// Items that produce no byte do not enter the queue. full rises while the 2-entry queue is full.
// Reset (synchronous, active high) clears the partial byte, pending count and queue.
module msb_first_bit_packer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   output logic                            full,
   input  logic                            req_mode,
   input  logic [mbp_pkg::FIELD_W-1:0]     req_field_value,
   input  logic [mbp_pkg::NUM_BITS_W-1:0]  req_num_bits,
   output logic                            empty,
   input  logic                            pop,
   output logic [mbp_pkg::BYTE_W-1:0]      rsp_out_byte,
   output logic                            rsp_last_byte
);

   logic                   accept;
   logic                   f_push;
   mbp_pkg::mbp_entry_type f_entry;
   mbp_pkg::mbp_entry_type head_entry;
   logic                   q_full, q_valid, q_pop;

   assign full   = q_full;
   assign accept = push && !q_full;

   mbp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .mode        (req_mode),
      .field_value (req_field_value),
      .num_bits    (req_num_bits),
      .q_push      (f_push),
      .q_entry     (f_entry)
   );

   mbp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (f_push),
      .push_entry (f_entry),
      .pop        (q_pop),
      .head_entry (head_entry),
      .q_full     (q_full),
      .q_valid    (q_valid)
   );

   mbp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .head_entry (head_entry),
      .q_pop      (q_pop),
      .pop        (pop),
      .empty      (empty),
      .out_byte   (rsp_out_byte),
      .last_byte  (rsp_last_byte)
   );

endmodule

// ----- sim/mbp_checker.sv -----
// Checker for the bit packer: predicts the byte stream and compares every popped byte.
module mbp_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  logic                           full,
   input  logic                           req_mode,
   input  logic [mbp_pkg::FIELD_W-1:0]    req_field_value,
   input  logic [mbp_pkg::NUM_BITS_W-1:0] req_num_bits,
   input  logic                           empty,
   input  logic                           pop,
   input  logic [mbp_pkg::BYTE_W-1:0]     rsp_out_byte,
   input  logic                           rsp_last_byte,
   output int                             fail_count,
   output int                             bytes_owed
);

   typedef struct packed {
      logic [mbp_pkg::BYTE_W-1:0] value;
      logic                       last;
   } owed_byte_type;

   owed_byte_type              owed_bytes[$];
   logic [mbp_pkg::BYTE_W-1:0] gathered;
   logic [mbp_pkg::PEND_W-1:0] filled;

   // Pack a write's bits MSB first, queue each full byte; a flush queues the partial byte.
   task automatic pack_field(input logic mode, input logic [mbp_pkg::FIELD_W-1:0] value,
                             input logic [mbp_pkg::NUM_BITS_W-1:0] width);
      int            remaining;
      int            first_new;
      owed_byte_type done_byte;
      first_new = owed_bytes.size();
      if (mode == mbp_pkg::MODE_FLUSH) begin
         if (filled != 0) begin
            done_byte.value = gathered;
            done_byte.last  = 1'b1;
            owed_bytes = {owed_bytes, done_byte};
            gathered = '0;
            filled   = '0;
         end
      end else begin
         remaining = (width > mbp_pkg::MAX_FIELD_BITS) ? mbp_pkg::MAX_FIELD_BITS
                     : int'(width);
         while (remaining > 0) begin
            gathered[7 - filled] = value[remaining - 1];
            if (filled == 3'd7) begin
               done_byte.value = gathered;
               done_byte.last  = 1'b0;
               owed_bytes = {owed_bytes, done_byte};
               gathered = '0;
               filled   = '0;
            end else begin
               filled = filled + 3'd1;
            end
            remaining--;
         end
         if (owed_bytes.size() > first_new)
            owed_bytes[owed_bytes.size() - 1].last = 1'b1;
      end
   endtask

   initial begin
      fail_count = 0;
      bytes_owed = 0;
      gathered   = '0;
      filled     = '0;
   end

   always @(posedge clock) begin
      owed_byte_type oldest;
      if (reset) begin
         gathered = '0;
         filled   = '0;
         owed_bytes.delete();
      end else begin
         if (pop && !empty) begin
            if (owed_bytes.size() == 0) begin
               $error("out_byte: expected nothing, got %h", rsp_out_byte);
               fail_count++;
            end else begin
               oldest = owed_bytes.pop_front();
               if (rsp_out_byte !== oldest.value) begin
                  $error("out_byte: expected %h, got %h", oldest.value, rsp_out_byte);
                  fail_count++;
               end
               if (rsp_last_byte !== oldest.last) begin
                  $error("last_byte: expected %b, got %b", oldest.last, rsp_last_byte);
                  fail_count++;
               end
            end
         end
         if (push && !full)
            pack_field(req_mode, req_field_value, req_num_bits);
      end
      bytes_owed = owed_bytes.size();
   end

endmodule

// ----- sim/tb.sv -----
// Testbench top for the bit packer: clock, reset, stimulus, back-pressure and verdict.
module tb;

   logic                           clock;
   logic                           reset;
   logic                           push;
   logic                           full;
   logic                           req_mode;
   logic [mbp_pkg::FIELD_W-1:0]    req_field_value;
   logic [mbp_pkg::NUM_BITS_W-1:0] req_num_bits;
   logic                           empty;
   logic                           pop;
   logic [mbp_pkg::BYTE_W-1:0]     rsp_out_byte;
   logic                           rsp_last_byte;
   int                             fail_count;
   int                             bytes_owed;
   bit                             quiet_tail;

   msb_first_bit_packer dut (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_mode        (req_mode),
      .req_field_value (req_field_value),
      .req_num_bits    (req_num_bits),
      .empty           (empty),
      .pop             (pop),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_byte   (rsp_last_byte)
   );

   mbp_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_mode        (req_mode),
      .req_field_value (req_field_value),
      .req_num_bits    (req_num_bits),
      .empty           (empty),
      .pop             (pop),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_byte   (rsp_last_byte),
      .fail_count      (fail_count),
      .bytes_owed      (bytes_owed)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Offer one transaction, hold it until accepted, return at the next falling edge.
   task automatic send_field(input logic mode, input logic [mbp_pkg::FIELD_W-1:0] value,
                             input logic [mbp_pkg::NUM_BITS_W-1:0] width);
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         push = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      push            = 1'b1;
      req_mode        = mode;
      req_field_value = value;
      req_num_bits    = width;
      do @(posedge clock); while (full);
      @(negedge clock);
   endtask

   // Result side: stall in random bursts until the tail of the run.
   initial begin
      pop = 1'b0;
      forever begin
         @(negedge clock);
         if (!reset && !quiet_tail && $urandom_range(0, 7) == 0) begin
            pop = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
         pop = !reset;
      end
   end

   initial begin
      int                             fields_sent;
      int                             pick;
      logic                           mode;
      logic [mbp_pkg::FIELD_W-1:0]    value;
      logic [mbp_pkg::NUM_BITS_W-1:0] width;
      push            = 1'b0;
      req_mode        = mbp_pkg::MODE_WRITE;
      req_field_value = '0;
      req_num_bits    = '0;
      quiet_tail      = 1'b0;
      reset           = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: zero width, empty flush, full widths, padding, saturation.
      send_field(mbp_pkg::MODE_WRITE, 32'hFFFF_FFFF, 6'd0);
      send_field(mbp_pkg::MODE_FLUSH, 32'hFFFF_FFFF, 6'd63);
      send_field(mbp_pkg::MODE_WRITE, 32'h0000_00A5, 6'd8);
      send_field(mbp_pkg::MODE_WRITE, 32'hFFFF_FFFF, 6'd32);
      send_field(mbp_pkg::MODE_WRITE, 32'h0000_0000, 6'd32);
      send_field(mbp_pkg::MODE_WRITE, 32'hFFFF_FFFD, 6'd3);
      send_field(mbp_pkg::MODE_WRITE, 32'h0000_0002, 6'd2);
      send_field(mbp_pkg::MODE_FLUSH, 32'h0000_0000, 6'd0);
      send_field(mbp_pkg::MODE_WRITE, 32'h0000_0001, 6'd1);
      send_field(mbp_pkg::MODE_WRITE, 32'h8000_0001, 6'd32);
      send_field(mbp_pkg::MODE_WRITE, 32'hDEAD_BEEF, 6'd63);
      send_field(mbp_pkg::MODE_WRITE, 32'h1234_5678, 6'd33);
      send_field(mbp_pkg::MODE_WRITE, 32'hFFFF_FF7F, 6'd7);
      send_field(mbp_pkg::MODE_WRITE, 32'h0000_0000, 6'd7);
      send_field(mbp_pkg::MODE_FLUSH, 32'h5A5A_A5A5, 6'd42);
      send_field(mbp_pkg::MODE_FLUSH, 32'h0000_0000, 6'd0);
      send_field(mbp_pkg::MODE_WRITE, 32'h0000_0000, 6'd40);
      send_field(mbp_pkg::MODE_WRITE, 32'hFFFF_FFFF, 6'd31);
      send_field(mbp_pkg::MODE_WRITE, 32'h7FFF_FFFE, 6'd0);
      send_field(mbp_pkg::MODE_FLUSH, 32'hFFFF_FFFF, 6'd63);
      send_field(mbp_pkg::MODE_WRITE, 32'h0000_000F, 6'd4);
      send_field(mbp_pkg::MODE_WRITE, 32'h0000_0001, 6'd16);
      send_field(mbp_pkg::MODE_FLUSH, 32'h0000_0000, 6'd32);

      fields_sent = 0;
      while (fields_sent < 357) begin
         if (fields_sent >= 300)
            quiet_tail = 1'b1;
         if ($urandom_range(0, 9) == 0) begin
            mode  = mbp_pkg::MODE_FLUSH;
            value = $urandom;
            width = mbp_pkg::NUM_BITS_W'($urandom);
         end else begin
            mode = mbp_pkg::MODE_WRITE;
            pick = $urandom_range(0, 7);
            case (pick)
               0: value = '0;
               1: value = '1;
               default: value = $urandom;
            endcase
            pick = $urandom_range(0, 15);
            if (pick == 0)
               width = '0;
            else if (pick <= 2)
               width = mbp_pkg::NUM_BITS_W'($urandom_range(33, 63));
            else
               width = mbp_pkg::NUM_BITS_W'($urandom_range(1, 32));
         end
         send_field(mode, value, width);
         fields_sent++;
      end
      push = 1'b0;

      while (bytes_owed != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (fail_count == 0 && bytes_owed == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #600000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/mbp_pkg.sv
rtl/mbp_front.sv
rtl/mbp_queue.sv
rtl/mbp_back.sv
rtl/msb_first_bit_packer.sv
sim/mbp_checker.sv
sim/tb.sv
